/* hdl/sem_pkg.sv */
`default_nettype none

package sem_pkg;

	localparam int PIX_W   = 8;
	localparam int SUM_W   = 10;
	localparam int CCOL_W  = 10;
	localparam int CROW_W  = 12;
	localparam int CFGW_W  = 11;
	localparam int CFGH_W  = 13;
	localparam int QDEPTH  = 4;
	localparam int QAW     = 2;
	localparam int QCW     = 3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [CFGW_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [CFGH_W-1:0] HEIGHT_RST = 13'd768;
	localparam logic [PIX_W-1:0]  MAG_MAX    = 8'd255;

	typedef struct packed {
		logic [PIX_W-1:0]  magnitude;
		logic [CCOL_W-1:0] center_col;
		logic [CROW_W-1:0] center_row;
		logic              last_in_frame;
	} result_t;

	typedef struct packed {
		logic [SUM_W-1:0] left;
		logic [SUM_W-1:0] right;
		logic [SUM_W-1:0] top;
		logic [SUM_W-1:0] bot;
	} sums_t;

endpackage

`default_nettype wire

/* hdl/sobel_edge_magnitude.sv */
// Sobel 3x3 edge magnitude, |gx|+|gy| saturated to 255, on a raster stream of 8-bit pixels.
// One pixel is taken per clock cycle while pixel_ready is high; the result for interior pixel
// (r-1,c-1) is registered in stage 1 and stage 2; border pixels give none. The two rows above
// are held in one MAX_WIDTH x 16 line memory read at the accept cycle and written back on the
// next, and a four-entry result queue decouples the output; pixel_ready drops only when that
// queue and the two pipeline stages could not absorb another result. Writing either register
// restarts the frame at row 0, column 0; widths and heights outside [3, MAX] are clamped.
// The line memory needs no clearing: entries are read for a result only after being written.
`default_nettype none

module sobel_edge_magnitude #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         pixel_valid,
	output logic                              pixel_ready,
	input  wire logic [sem_pkg::PIX_W-1:0]    pixel,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic      [sem_pkg::PIX_W-1:0]    magnitude,
	output logic      [sem_pkg::CCOL_W-1:0]   center_col,
	output logic      [sem_pkg::CROW_W-1:0]   center_row,
	output logic                              last_in_frame
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int LW = 2 * sem_pkg::PIX_W;

	// configuration
	logic [sem_pkg::CFGW_W-1:0] width_q;
	logic [sem_pkg::CFGH_W-1:0] height_q;
	logic                       cfg_wr;
	logic [31:0]                w_eff, h_eff;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sem_pkg::WIDTH_RST;
			height_q <= sem_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				sem_pkg::REG_WIDTH:  width_q  <= pwdata[sem_pkg::CFGW_W-1:0];
				sem_pkg::REG_HEIGHT: height_q <= pwdata[sem_pkg::CFGH_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			sem_pkg::REG_WIDTH:  prdata = 32'(width_q);
			sem_pkg::REG_HEIGHT: prdata = 32'(height_q);
		endcase
	end

	always_comb begin
		priority if (32'(width_q) < 32'd3) begin
			w_eff = 32'd3;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end else begin
			w_eff = 32'(width_q);
		end
		priority if (32'(height_q) < 32'd3) begin
			h_eff = 32'd3;
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = 32'(MAX_HEIGHT);
		end else begin
			h_eff = 32'(height_q);
		end
	end

	// position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept, col_end, row_end, emit;

	assign accept  = pixel_valid & pixel_ready;
	assign col_end = (32'(col_q) + 32'd1) >= w_eff;
	assign row_end = (32'(row_q) + 32'd1) >= h_eff;
	assign emit    = (32'(col_q) >= 32'd2) && (32'(row_q) >= 32'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : RW'(32'(row_q) + 32'd1);
			end else begin
				col_q <= CW'(32'(col_q) + 32'd1);
			end
		end
	end

	// line memory: [15:8] two rows above, [7:0] one row above
	logic [LW-1:0] lines_mem [MAX_WIDTH];
	logic [LW-1:0] rd_s1;

	// stage 1
	logic                       v_s1, emit_s1, last_s1;
	logic [CW-1:0]              col_s1;
	logic [sem_pkg::PIX_W-1:0]  pix_s1;
	logic [sem_pkg::CCOL_W-1:0] ccol_s1;
	logic [sem_pkg::CROW_W-1:0] crow_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= lines_mem[col_q];
		end
		if (v_s1) begin
			lines_mem[col_s1] <= {rd_s1[sem_pkg::PIX_W-1:0], pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= col_q;
			pix_s1  <= pixel;
			emit_s1 <= emit;
			last_s1 <= col_end & row_end;
			ccol_s1 <= sem_pkg::CCOL_W'(32'(col_q) - 32'd1);
			crow_s1 <= sem_pkg::CROW_W'(32'(row_q) - 32'd1);
		end
	end

	// window: [0..2] column c-2, [3..5] column c-1 (top, mid, bottom)
	logic [sem_pkg::PIX_W-1:0] win_q [6];
	logic [sem_pkg::PIX_W-1:0] d0, d1, d2;
	sem_pkg::sums_t            sums;

	assign d0 = rd_s1[LW-1:sem_pkg::PIX_W];
	assign d1 = rd_s1[sem_pkg::PIX_W-1:0];
	assign d2 = pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= d0;
			win_q[4] <= d1;
			win_q[5] <= d2;
		end
	end

	always_comb begin
		sums.left  = sem_pkg::SUM_W'(win_q[0]) + {1'b0, win_q[1], 1'b0}
		             + sem_pkg::SUM_W'(win_q[2]);
		sums.right = sem_pkg::SUM_W'(d0) + {1'b0, d1, 1'b0} + sem_pkg::SUM_W'(d2);
		sums.top   = sem_pkg::SUM_W'(win_q[0]) + {1'b0, win_q[3], 1'b0}
		             + sem_pkg::SUM_W'(d0);
		sums.bot   = sem_pkg::SUM_W'(win_q[2]) + {1'b0, win_q[5], 1'b0}
		             + sem_pkg::SUM_W'(d2);
	end

	// stage 2
	logic                       v_s2, last_s2;
	sem_pkg::sums_t             sums_s2;
	logic [sem_pkg::CCOL_W-1:0] ccol_s2;
	logic [sem_pkg::CROW_W-1:0] crow_s2;
	logic [sem_pkg::SUM_W-1:0]  adx, ady;
	logic [sem_pkg::SUM_W:0]    mag_sum;
	sem_pkg::result_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 & emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sums_s2 <= sums;
			ccol_s2 <= ccol_s1;
			crow_s2 <= crow_s1;
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		adx = (sums_s2.left >= sums_s2.right) ? sums_s2.left - sums_s2.right
		                                       : sums_s2.right - sums_s2.left;
		ady = (sums_s2.top >= sums_s2.bot) ? sums_s2.top - sums_s2.bot
		                                   : sums_s2.bot - sums_s2.top;
		mag_sum = {1'b0, adx} + {1'b0, ady};
		res.magnitude     = (mag_sum > (sem_pkg::SUM_W+1)'(sem_pkg::MAG_MAX))
		                    ? sem_pkg::MAG_MAX : mag_sum[sem_pkg::PIX_W-1:0];
		res.center_col    = ccol_s2;
		res.center_row    = crow_s2;
		res.last_in_frame = last_s2;
	end

	// result queue
	sem_pkg::result_t           q_mem [sem_pkg::QDEPTH];
	logic [sem_pkg::QAW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [sem_pkg::QCW-1:0]    cnt_q;
	logic                       pop;
	sem_pkg::result_t           head;

	assign pop          = result_valid & result_ready;
	assign result_valid = (cnt_q != '0);
	assign pixel_ready  = (cnt_q + sem_pkg::QCW'(v_s1) + sem_pkg::QCW'(v_s2))
	                      < sem_pkg::QCW'(sem_pkg::QDEPTH);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			q_mem[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + sem_pkg::QCW'(v_s2) - sem_pkg::QCW'(pop);
		end
	end

	assign head          = q_mem[rd_ptr_q];
	assign magnitude     = head.magnitude;
	assign center_col    = head.center_col;
	assign center_row    = head.center_row;
	assign last_in_frame = head.last_in_frame;

endmodule

`default_nettype wire

/* hdl/sem_checker.sv */
`default_nettype none

module sem_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       psel,
	input wire logic                       pwrite,
	input wire logic [2:0]                 paddr,
	input wire logic [31:0]                prdata,
	input wire logic                       pready,
	input wire logic                       result_valid,
	input wire logic                       result_ready,
	input wire logic [sem_pkg::PIX_W-1:0]  magnitude,
	input wire logic [sem_pkg::CCOL_W-1:0] center_col,
	input wire logic [sem_pkg::CROW_W-1:0] center_row,
	input wire logic                       last_in_frame
);

	// a stalled result transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(magnitude)
		&& $stable(center_col) && $stable(center_row) && $stable(last_in_frame))
		else $error("result changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_width_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[2] == sem_pkg::REG_WIDTH |-> prdata[31:sem_pkg::CFGW_W] == '0)
		else $error("width readback wider than register");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> center_col != '0 && center_row != '0)
		else $error("result for a border pixel");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

`default_nettype wire

/* verif/sobel_magnitude_checker.sv */
`timescale 1ns / 100ps

module sobel_magnitude_checker #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pixel_valid,
	input  logic                         pixel_ready,
	input  logic [sem_pkg::PIX_W-1:0]    pixel,
	input  logic                         result_valid,
	input  logic                         result_ready,
	input  logic [sem_pkg::PIX_W-1:0]    magnitude,
	input  logic [sem_pkg::CCOL_W-1:0]   center_col,
	input  logic [sem_pkg::CROW_W-1:0]   center_row,
	input  logic                         last_in_frame,
	output int                           pending,
	output int                           errors
);

	localparam logic [2:0] WIDTH_ADDR  = {sem_pkg::REG_WIDTH, 2'b00};
	localparam logic [2:0] HEIGHT_ADDR = {sem_pkg::REG_HEIGHT, 2'b00};

	logic [sem_pkg::CFGW_W-1:0] width_reg;
	logic [sem_pkg::CFGH_W-1:0] height_reg;
	logic [sem_pkg::PIX_W-1:0]  row_prev  [0:MAX_WIDTH-1];
	logic [sem_pkg::PIX_W-1:0]  row_prev2 [0:MAX_WIDTH-1];
	logic [sem_pkg::PIX_W-1:0]  win [0:5];
	logic [sem_pkg::CCOL_W-1:0] col_pos;
	logic [sem_pkg::CROW_W-1:0] row_pos;
	sem_pkg::result_t           mag_expected [$];

	task automatic flag_mismatch(input string msg);
		begin
			errors++;
			$display("%0t mismatch: %s", $time, msg);
		end
	endtask

	task automatic shift_in_pixel(input logic [sem_pkg::PIX_W-1:0] p);
		int w, h, c, r, idx, lft, rgt, up, dn, mag;
		logic [sem_pkg::PIX_W-1:0] t, m;
		sem_pkg::result_t res;
		begin
			w = int'(width_reg);
			if (w < 3) w = 3;
			else if (w > MAX_WIDTH) w = MAX_WIDTH;
			h = int'(height_reg);
			if (h < 3) h = 3;
			else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
			c = int'(col_pos);
			r = int'(row_pos);
			idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
			t = row_prev2[idx];
			m = row_prev[idx];
			row_prev2[idx] = m;
			row_prev[idx] = p;
			if (r >= 2 && c >= 2) begin
				lft = win[0] + 2 * win[1] + win[2];
				rgt = t + 2 * m + p;
				up  = win[0] + 2 * win[3] + t;
				dn  = win[2] + 2 * win[5] + p;
				mag = ((lft > rgt) ? lft - rgt : rgt - lft) + ((up > dn) ? up - dn : dn - up);
				if (mag > 255) mag = 255;
				res.magnitude     = mag[sem_pkg::PIX_W-1:0];
				res.center_col    = sem_pkg::CCOL_W'(c - 1);
				res.center_row    = sem_pkg::CROW_W'(r - 1);
				res.last_in_frame = (r + 1 >= h) && (c + 1 >= w);
				mag_expected.push_back(res);
			end
			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = t;
			win[4] = m;
			win[5] = p;
			if (c + 1 >= w) begin
				col_pos = '0;
				row_pos = (r + 1 >= h) ? '0 : sem_pkg::CROW_W'(r + 1);
			end else begin
				col_pos = sem_pkg::CCOL_W'(c + 1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sem_pkg::result_t exp_res;
		if (!arst_n) begin
			width_reg  = sem_pkg::WIDTH_RST;
			height_reg = sem_pkg::HEIGHT_RST;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				row_prev[i]  = '0;
				row_prev2[i] = '0;
			end
			for (int i = 0; i < 6; i++)
				win[i] = '0;
			col_pos = '0;
			row_pos = '0;
			mag_expected.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == WIDTH_ADDR) begin
					width_reg = pwdata[sem_pkg::CFGW_W-1:0];
					col_pos = '0;
					row_pos = '0;
				end else if (paddr == HEIGHT_ADDR) begin
					height_reg = pwdata[sem_pkg::CFGH_W-1:0];
					col_pos = '0;
					row_pos = '0;
				end
			end
			if (result_valid && result_ready) begin
				if (mag_expected.size() == 0) begin
					flag_mismatch($sformatf("unexpected result at col %0d row %0d",
						center_col, center_row));
				end else begin
					exp_res = mag_expected.pop_front();
					if (magnitude !== exp_res.magnitude)
						flag_mismatch($sformatf("magnitude %0d, expected %0d (col %0d row %0d)",
							magnitude, exp_res.magnitude, exp_res.center_col,
							exp_res.center_row));
					if (center_col !== exp_res.center_col)
						flag_mismatch($sformatf("center_col %0d, expected %0d",
							center_col, exp_res.center_col));
					if (center_row !== exp_res.center_row)
						flag_mismatch($sformatf("center_row %0d, expected %0d",
							center_row, exp_res.center_row));
					if (last_in_frame !== exp_res.last_in_frame)
						flag_mismatch($sformatf("last_in_frame %0b, expected %0b (col %0d row %0d)",
							last_in_frame, exp_res.last_in_frame, exp_res.center_col,
							exp_res.center_row));
				end
			end
			if (pixel_valid && pixel_ready)
				shift_in_pixel(pixel);
		end
		pending = mag_expected.size();
	end

endmodule

/* verif/tb_sobel_edge_magnitude.sv */
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude;

	localparam int         MAX_W       = 1024;
	localparam int         MAX_H       = 4096;
	localparam int         QUIET_LIMIT = 1000;
	localparam int         SETTLE      = 12;
	localparam int         ITEMS       = 1650;
	localparam logic [2:0] WIDTH_ADDR  = {sem_pkg::REG_WIDTH, 2'b00};
	localparam logic [2:0] HEIGHT_ADDR = {sem_pkg::REG_HEIGHT, 2'b00};

	// three 3x3 frames: strong vertical edge, flat black, gentle ramp
	localparam logic [27*8-1:0] DIRECTED_PX = {
		8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9
	};

	typedef enum int {PAT_NOISE, PAT_FLAT, PAT_RAMP, PAT_BINARY} pattern_t;

	logic                       clk;
	logic                       arst_n       = 1'b0;
	logic                       psel         = 1'b0;
	logic                       penable      = 1'b0;
	logic                       pwrite       = 1'b0;
	logic [2:0]                 paddr        = '0;
	logic [31:0]                pwdata       = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       pixel_valid  = 1'b0;
	logic                       pixel_ready;
	logic [sem_pkg::PIX_W-1:0]  pixel        = '0;
	logic                       result_valid;
	logic                       result_ready = 1'b0;
	logic [sem_pkg::PIX_W-1:0]  magnitude;
	logic [sem_pkg::CCOL_W-1:0] center_col;
	logic [sem_pkg::CROW_W-1:0] center_row;
	logic                       last_in_frame;
	int                         pending;
	int                         errors;
	int                         quiet_cycles = 0;
	bit                         calm = 1'b0;

	sobel_edge_magnitude #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
		.result_valid(result_valid), .result_ready(result_ready),
		.magnitude(magnitude), .center_col(center_col), .center_row(center_row),
		.last_in_frame(last_in_frame)
	);

	sobel_magnitude_checker #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
		.result_valid(result_valid), .result_ready(result_ready),
		.magnitude(magnitude), .center_col(center_col), .center_row(center_row),
		.last_in_frame(last_in_frame),
		.pending(pending), .errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		result_ready <= calm || ($urandom_range(0, 99) >= 8);
	end

	always @(posedge clk) begin
		if ((pixel_valid && pixel_ready) || (result_valid && result_ready) ||
			(psel && penable && pwrite && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** sobel_edge_magnitude: FAILED **");
			$finish;
		end
	end

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= addr;
			pwdata  <= data;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_pixel(input logic [sem_pkg::PIX_W-1:0] p);
		int gap;
		begin
			if (!calm && $urandom_range(0, 99) < 8) begin
				gap = $urandom_range(1, 4);
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pixel_valid <= 1'b1;
			pixel       <= p;
			do @(posedge clk); while (!pixel_ready);
		end
	endtask

	// let every transfer and the pipeline tail settle before touching registers
	task automatic drain;
		begin
			pixel_valid <= 1'b0;
			do @(negedge clk); while (pending != 0);
			repeat (SETTLE) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] pattern_pixel(input pattern_t style, input int base,
		input int col, input int row);
		case (style)
			PAT_NOISE:  return 8'($urandom_range(0, 255));
			PAT_FLAT:   return 8'(base + $urandom_range(0, 15));
			PAT_RAMP:   return 8'(col * (base % 7 + 1) + row * 5);
			default:    return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		endcase
	endfunction

	task automatic run_frames(input int wval, input int hval, input int count,
		input pattern_t style);
		int w, base;
		begin
			w = wval & 'h7FF;
			if (w < 3) w = 3;
			else if (w > MAX_W) w = MAX_W;
			base = $urandom_range(0, 240);
			cfg_write(WIDTH_ADDR, wval);
			cfg_write(HEIGHT_ADDR, hval);
			for (int i = 0; i < count; i++)
				send_pixel(pattern_pixel(style, base, i % w, i / w));
			drain();
		end
	endtask

	initial begin
		int sent, w, h, count;
		pattern_t style;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_write(WIDTH_ADDR, 3);
		cfg_write(HEIGHT_ADDR, 3);
		for (int i = 0; i < 27; i++)
			send_pixel(DIRECTED_PX[(26 - i) * 8 +: 8]);
		drain();

		// clamping from below, oversized width and height
		run_frames(0, 0, 31, PAT_NOISE);
		run_frames(2047, 3, 40, PAT_RAMP);
		run_frames(3, 8191, 60, PAT_FLAT);

		sent = 27 + 31 + 40 + 60;
		while (sent < ITEMS) begin
			calm = (sent >= 600) && (sent < 1000);
			style = pattern_t'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(0, 2047);
				h = $urandom_range(0, 8191);
				count = $urandom_range(20, 200);
			end else begin
				w = $urandom_range(3, 48);
				h = $urandom_range(3, 10);
				count = $urandom_range(1, 2) * w * h;
				// cut some frames short so the next write restarts mid-frame
				if ($urandom_range(0, 3) == 0)
					count += $urandom_range(1, w * h - 1);
			end
			if (count > ITEMS - sent)
				count = ITEMS - sent;
			run_frames(w, h, count, style);
			sent += count;
		end
		calm = 1'b0;

		if (errors == 0)
			$display("** sobel_edge_magnitude: PASSED **");
		else
			$display("** sobel_edge_magnitude: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
hdl/sem_pkg.sv
hdl/sobel_edge_magnitude.sv
hdl/sem_checker.sv
verif/sobel_magnitude_checker.sv
verif/tb_sobel_edge_magnitude.sv
